// ===== hw/rtl/nss_pkg.sv =====
`timescale 1ns / 1ps
package nss_pkg;

  // automaton size
  localparam int NUM_STATES = 32;
  localparam int NUM_LABELS = 16;
  localparam int STATE_W    = 5;
  localparam int LABEL_W    = 4;

  // labeled transition memory: one row per (label, source state)
  localparam int MEM_AW    = LABEL_W + STATE_W;
  localparam int MEM_DEPTH = NUM_LABELS * NUM_STATES;

  // configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;
  localparam int COUNT_W    = 6;
  localparam int ALPHA_W    = 5;

  localparam logic [CFG_IDX_W-1:0] CFG_STATE_COUNT    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ALPHABET_SIZE  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EPSILON_ENABLE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_MASK   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_FINAL_MASK     = 3'd4;

  // edge label code for an epsilon transition
  localparam logic signed [4:0] LABEL_EPSILON = -5'sd1;

  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_RESTART = 2'd1,
    OP_SYMBOL  = 2'd2,
    OP_NONE    = 2'd3
  } nss_op_e;

  typedef enum logic [1:0] {
    LAB_ROW,
    LAB_EPS,
    LAB_NONE
  } nss_lab_e;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_CLOSE_PRE,
    ST_GATHER,
    ST_DRAIN,
    ST_CLOSE_POST,
    ST_FINISH
  } nss_state_e;

  typedef struct packed {
    logic item_load;
    logic clr_step;
    logic eps_write;
    logic rmw_write;
    logic s_load_init;
    logic s_load_active;
    logic close_step;
    logic gather_start;
    logic gather_issue;
    logic gather_drain;
    logic commit_active;
    logic result_load;
  } nss_cmd_t;

  typedef struct packed {
    nss_op_e  op;
    nss_lab_e lab_kind;
    logic     bad;
    logic     clos_done;
    logic     gather_last;
    logic     clr_last;
    logic     out_free;
  } nss_status_t;

endpackage

// ===== hw/rtl/nss_item_if.sv =====
`timescale 1ns / 1ps
interface nss_item_if;
  logic              valid;
  logic              ready;
  logic [1:0]        operation;
  logic [4:0]        source_state;
  logic signed [4:0] edge_label;
  logic [4:0]        target_state;
  logic              edge_present;
  logic [3:0]        symbol;

  modport source (
    output valid, operation, source_state, edge_label, target_state, edge_present, symbol,
    input  ready
  );
  modport sink (
    input  valid, operation, source_state, edge_label, target_state, edge_present, symbol,
    output ready
  );
endinterface

// ===== hw/rtl/nss_result_if.sv =====
`timescale 1ns / 1ps
interface nss_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] active_states;
  logic        accepting;
  logic        dead;
  logic        bad_symbol;

  modport source (
    output valid, active_states, accepting, dead, bad_symbol,
    input  ready
  );
  modport sink (
    input  valid, active_states, accepting, dead, bad_symbol,
    output ready
  );
endinterface

// ===== hw/rtl/nss_controller.sv =====
`timescale 1ns / 1ps
module nss_controller import nss_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        item_valid_i,
  output logic        item_ready_o,
  input  nss_status_t status_i,
  output nss_cmd_t    cmd_o
);

  nss_state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR: begin
        if (status_i.clr_last) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (item_valid_i) state_d = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        case (status_i.op)
          OP_WRITE: begin
            state_d = (status_i.lab_kind == LAB_ROW) ? ST_RMW_RD : ST_FINISH;
          end
          OP_RESTART: state_d = ST_CLOSE_POST;
          OP_SYMBOL: begin
            state_d = status_i.bad ? ST_FINISH : ST_CLOSE_PRE;
          end
          default: state_d = ST_FINISH;
        endcase
      end
      ST_RMW_RD: state_d = ST_RMW_WR;
      ST_RMW_WR: state_d = ST_FINISH;
      ST_CLOSE_PRE: begin
        if (status_i.clos_done) state_d = ST_GATHER;
      end
      ST_GATHER: begin
        if (status_i.gather_last) state_d = ST_DRAIN;
      end
      ST_DRAIN: state_d = ST_CLOSE_POST;
      ST_CLOSE_POST: begin
        if (status_i.clos_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (status_i.out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_CLEAR;
    endcase
  end

  // datapath commands
  always_comb begin
    cmd_o        = '0;
    item_ready_o = 1'b0;
    case (state_q)
      ST_CLEAR: cmd_o.clr_step = 1'b1;
      ST_IDLE: begin
        item_ready_o    = 1'b1;
        cmd_o.item_load = item_valid_i;
      end
      ST_DISPATCH: begin
        cmd_o.eps_write     = (status_i.op == OP_WRITE) && (status_i.lab_kind == LAB_EPS);
        cmd_o.s_load_init   = (status_i.op == OP_RESTART);
        cmd_o.s_load_active = (status_i.op == OP_SYMBOL) && !status_i.bad;
      end
      ST_RMW_RD: ;
      ST_RMW_WR: cmd_o.rmw_write = 1'b1;
      ST_CLOSE_PRE: begin
        cmd_o.close_step   = 1'b1;
        cmd_o.gather_start = status_i.clos_done;
      end
      ST_GATHER: cmd_o.gather_issue = 1'b1;
      ST_DRAIN:  cmd_o.gather_drain = 1'b1;
      ST_CLOSE_POST: begin
        cmd_o.close_step    = 1'b1;
        cmd_o.commit_active = status_i.clos_done;
      end
      ST_FINISH: cmd_o.result_load = status_i.out_free;
      default: ;
    endcase
  end

endmodule

// ===== hw/rtl/nss_datapath.sv =====
`timescale 1ns / 1ps
module nss_datapath import nss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  nss_item_if.sink              item_i,
  nss_result_if.source          result_o,
  input  nss_cmd_t              cmd_i,
  output nss_status_t           status_o
);

  // configuration registers
  logic [COUNT_W-1:0]    state_count_q;
  logic [ALPHA_W-1:0]    alphabet_size_q;
  logic                  epsilon_enable_q;
  logic [NUM_STATES-1:0] initial_mask_q;
  logic [NUM_STATES-1:0] final_mask_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_count_q    <= COUNT_W'(NUM_STATES);
      alphabet_size_q  <= ALPHA_W'(NUM_LABELS);
      epsilon_enable_q <= 1'b0;
      initial_mask_q   <= NUM_STATES'(1);
      final_mask_q     <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STATE_COUNT:    state_count_q    <= cfg_data_i[COUNT_W-1:0];
        CFG_ALPHABET_SIZE:  alphabet_size_q  <= cfg_data_i[ALPHA_W-1:0];
        CFG_EPSILON_ENABLE: epsilon_enable_q <= cfg_data_i[0];
        CFG_INITIAL_MASK:   initial_mask_q   <= cfg_data_i[NUM_STATES-1:0];
        CFG_FINAL_MASK:     final_mask_q     <= cfg_data_i[NUM_STATES-1:0];
        default: ;
      endcase
    end
  end

  // captured input transaction
  nss_op_e            op_q;
  logic [STATE_W-1:0] src_q;
  logic signed [4:0]  lab_q;
  logic [STATE_W-1:0] dst_q;
  logic               present_q;
  logic [LABEL_W-1:0] sym_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      op_q      <= nss_op_e'(item_i.operation);
      src_q     <= item_i.source_state;
      lab_q     <= item_i.edge_label;
      dst_q     <= item_i.target_state;
      present_q <= item_i.edge_present;
      sym_q     <= item_i.symbol;
    end
  end

  // states in use and symbol range
  logic [NUM_STATES-1:0] state_mask;
  logic [ALPHA_W-1:0]    alpha;
  logic                  bad;
  nss_lab_e              lab_kind;

  always_comb begin
    if (state_count_q >= COUNT_W'(NUM_STATES)) begin
      state_mask = '1;
    end else begin
      state_mask = (NUM_STATES'(1) << state_count_q[STATE_W-1:0]) - NUM_STATES'(1);
    end
    alpha = (alphabet_size_q > ALPHA_W'(NUM_LABELS)) ? ALPHA_W'(NUM_LABELS) : alphabet_size_q;
    bad   = (op_q == OP_SYMBOL) && ({1'b0, sym_q} >= alpha);
    if (lab_q == LABEL_EPSILON) begin
      lab_kind = LAB_EPS;
    end else if (!lab_q[4]) begin
      lab_kind = LAB_ROW;
    end else begin
      lab_kind = LAB_NONE;
    end
  end

  // epsilon rows, one per source state
  logic [NUM_STATES-1:0] eps_q [NUM_STATES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_STATES; i++) eps_q[i] <= '0;
    end else if (cmd_i.eps_write) begin
      eps_q[src_q][dst_q] <= present_q;
    end
  end

  // labeled transition memory
  logic [NUM_STATES-1:0] mem [MEM_DEPTH];
  logic [NUM_STATES-1:0] rdata_q;
  logic [MEM_AW-1:0]     clr_cnt_q;
  logic [STATE_W-1:0]    gather_cnt_q;
  logic [MEM_AW-1:0]     item_addr;
  logic [MEM_AW-1:0]     mem_raddr;
  logic [MEM_AW-1:0]     mem_waddr;
  logic [NUM_STATES-1:0] mem_wdata;
  logic                  mem_we;
  logic [NUM_STATES-1:0] dst_bit;

  assign item_addr = {lab_q[LABEL_W-1:0], src_q};
  assign dst_bit   = NUM_STATES'(1) << dst_q;
  assign mem_raddr = cmd_i.gather_issue ? {sym_q, gather_cnt_q} : item_addr;
  assign mem_we    = cmd_i.clr_step | cmd_i.rmw_write;
  assign mem_waddr = cmd_i.clr_step ? clr_cnt_q : item_addr;

  always_comb begin
    if (cmd_i.clr_step) begin
      mem_wdata = '0;
    end else if (present_q) begin
      mem_wdata = rdata_q | dst_bit;
    end else begin
      mem_wdata = rdata_q & ~dst_bit;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    rdata_q <= mem[mem_raddr];
  end

  // clearing sweep counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_cnt_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_cnt_q <= clr_cnt_q + MEM_AW'(1);
    end
  end

  // working set and one epsilon closure pass
  logic [NUM_STATES-1:0] s_q;
  logic [NUM_STATES-1:0] eps_hit;
  logic [NUM_STATES-1:0] close_nxt;

  always_comb begin
    eps_hit = '0;
    for (int i = 0; i < NUM_STATES; i++) begin
      if (s_q[i]) eps_hit = eps_hit | eps_q[i];
    end
    close_nxt = epsilon_enable_q ? ((s_q | eps_hit) & state_mask) : (s_q & state_mask);
  end

  // successor gather over the source states
  logic                  pend_q;
  logic [NUM_STATES-1:0] acc_q;
  logic [NUM_STATES-1:0] acc_sum;
  logic [NUM_STATES-1:0] active_q;

  assign acc_sum = pend_q ? (acc_q | rdata_q) : acc_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gather_cnt_q <= '0;
      pend_q       <= 1'b0;
    end else begin
      pend_q <= cmd_i.gather_issue & s_q[gather_cnt_q];
      if (cmd_i.gather_start) begin
        gather_cnt_q <= '0;
      end else if (cmd_i.gather_issue) begin
        gather_cnt_q <= gather_cnt_q + STATE_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.gather_start) begin
      acc_q <= '0;
    end else begin
      acc_q <= acc_sum;
    end
    if (cmd_i.s_load_init) begin
      s_q <= initial_mask_q & state_mask;
    end else if (cmd_i.s_load_active) begin
      s_q <= active_q & state_mask;
    end else if (cmd_i.gather_drain) begin
      s_q <= acc_sum & state_mask;
    end else if (cmd_i.close_step) begin
      s_q <= close_nxt;
    end
  end

  // committed active set
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= '0;
    end else if (cmd_i.commit_active) begin
      active_q <= s_q;
    end
  end

  // result register
  logic out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.result_load) begin
      out_valid_q <= 1'b1;
    end else if (result_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.result_load) begin
      result_o.active_states <= active_q;
      result_o.accepting     <= |(active_q & final_mask_q);
      result_o.dead          <= (active_q == '0);
      result_o.bad_symbol    <= bad;
    end
  end

  assign result_o.valid = out_valid_q;

  // status to the controller
  always_comb begin
    status_o.op          = op_q;
    status_o.lab_kind    = lab_kind;
    status_o.bad         = bad;
    status_o.clos_done   = (close_nxt == s_q);
    status_o.gather_last = (gather_cnt_q == STATE_W'(NUM_STATES - 1));
    status_o.clr_last    = (clr_cnt_q == MEM_AW'(MEM_DEPTH - 1));
    status_o.out_free    = !out_valid_q || result_o.ready;
  end

endmodule

// ===== hw/rtl/nfa_symbol_step_core.sv =====
`timescale 1ns / 1ps
// Steps a nondeterministic automaton of 32 states over 16 symbols, keeping the
// active states as a bit set. After reset the labeled transition memory is
// swept to zero, one row a cycle. No transaction is accepted then, while
// configuration writes are taken as usual. One transaction is processed at a
// time. An epsilon transition write or an ignored transition write goes from
// dispatch straight to the result. A labeled transition write is a
// read-modify-write of its memory row, a read state and then a write state. A
// restart loads the initial set and runs epsilon closure passes until the set
// stops growing. A symbol runs closure passes on the active set, gathers the
// successors, then runs closure passes again. The successor gather reads one
// memory row per source state, which is 32 reads through the one read port.
// Each closure pass works over the epsilon rows held in flops. With epsilon
// disabled no closure pass grows the set. An out-of-range symbol goes straight
// to the result and leaves the set unchanged. A result waits to be loaded while
// the previous result still waits in the output register. The next transaction
// is accepted once the previous result is in the output register, even if it
// has not been taken yet.
module nfa_symbol_step_core import nss_pkg::*; (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  nss_item_if.sink              item_i,
  nss_result_if.source          result_o
);

  nss_cmd_t    cmd;
  nss_status_t status;
  logic        item_ready;

  assign item_i.ready = item_ready;

  // sequencing
  nss_controller u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .item_valid_i (item_i.valid),
    .item_ready_o (item_ready),
    .status_i     (status),
    .cmd_o        (cmd)
  );

  // storage and set logic
  nss_datapath u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .item_i     (item_i),
    .result_o   (result_o),
    .cmd_i      (cmd),
    .status_o   (status)
  );

  // one transaction in flight: acceptance closes the input for the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_ready) |=> !item_ready)
    else $error("input accepted while a transaction is in flight");

  // a result is never loaded over one that is still waiting
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.result_load |-> (!result_o.valid || result_o.ready))
    else $error("pending result overwritten");

  // an empty set cannot accept
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.dead) |-> !result_o.accepting)
    else $error("dead set reported as accepting");

  // memory sweep never overlaps a symbol gather, a labeled write or input acceptance
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.clr_step |-> (!cmd.gather_issue && !cmd.rmw_write && !item_ready))
    else $error("memory access during clearing sweep");

endmodule
